>>> src/unfrozen_relperm_blend_unit_macros.svh
`ifndef UNFROZEN_RELPERM_BLEND_UNIT_MACROS_SVH
`define UNFROZEN_RELPERM_BLEND_UNIT_MACROS_SVH

// Checks that cond holds at delay n after trig, sampled on clock.
`define URB_ASSERT_DELAY(label, trig, n, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> ##(n) (cond)) \
      else $error("delayed check failed");

// Checks that cond holds in the same cycle as trig.
`define URB_ASSERT_NOW(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error("same cycle check failed");

`endif

>>> src/urb_pkg.sv
package urb_pkg;

   localparam int Q = 30;
   localparam logic [30:0] Q_ONE = 31'h4000_0000;
   localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
   localparam logic signed [33:0] ATM_UNITS = 34'sd25939200;

   localparam int TERMS = 8;
   localparam int SINE_LATENCY = 2 * TERMS + 3;

   localparam int DEN_W = 22;
   localparam int QUO_W = 31;
   localparam int DVD_W = 52;

   localparam logic [4:0] PE_RESET = 5'd4;
   localparam logic signed [21:0] UPPER_RESET = 22'sd2560;
   localparam logic signed [21:0] LOWER_RESET = 22'sd0;

   typedef enum logic [1:0] {
      CSR_POWER_EXPONENT = 2'd0,
      CSR_UPPER_CUTOFF   = 2'd1,
      CSR_LOWER_CUTOFF   = 2'd2
   } urb_csr_type;

   typedef enum logic [1:0] {
      CLS_BLEND,
      CLS_ONE,
      CLS_FULL
   } urb_class_type;

   typedef struct packed {
      urb_class_type cls;
      logic [30:0]   p;
   } urb_side_type;

   // Reciprocal of the Taylor divisor (2n)(2n+1), rounded up, for an exact
   // quotient of any 32-bit dividend after the matching right shift.
   function automatic logic [32:0] term_mult(input int n);
      case (n)
         1: return 33'd5726623062;
         2: return 33'd6871947674;
         3: return 33'd6544712071;
         4: return 33'd7635497416;
         5: return 33'd4997780127;
         6: return 33'd7048151461;
         7: return 33'd5235769657;
         8: return 33'd8084644322;
         default: return 33'd0;
      endcase
   endfunction

   function automatic int term_shift(input int n);
      case (n)
         1: return 35;
         2: return 37;
         3: return 38;
         4: return 39;
         5: return 39;
         6: return 40;
         7: return 40;
         8: return 41;
         default: return 0;
      endcase
   endfunction

   // Half of the divisor, added before the division to round to nearest.
   function automatic logic [7:0] term_half(input int n);
      case (n)
         1: return 8'd3;
         2: return 8'd10;
         3: return 8'd21;
         4: return 8'd36;
         5: return 8'd55;
         6: return 8'd78;
         7: return 8'd105;
         8: return 8'd136;
         default: return 8'd0;
      endcase
   endfunction

endpackage

>>> src/urb_sine.sv
module urb_sine #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [FRAC_BITS:0]   in_uf,
   output logic                 out_valid,
   output logic [30:0]          out_sine
);

   localparam int PW = FRAC_BITS + 32;
   localparam logic [PW-1:0] T_HALF = PW'(1) << (FRAC_BITS - 1);
   localparam logic [61:0] SQ_HALF = 62'(1) << 29;
   localparam logic [62:0] PR_HALF = 63'(1) << 29;
   localparam logic signed [34:0] ACC_ONE = 35'sh4000_0000;
   localparam int TN = urb_pkg::TERMS;

   logic [PW-1:0] t_prod_in;
   logic [30:0]   a_t_in;
   logic          a_valid_ff;
   logic [30:0]   a_t_ff;

   logic [61:0]   b_sq_in;
   logic          b_valid_ff;
   logic [30:0]   b_t_ff;
   logic [31:0]   b_t2_ff;
   logic signed [34:0] b_acc_ff;

   logic               p_valid_ff [TN];
   logic [31:0]        p_x_ff     [TN];
   logic [31:0]        p_t2_ff    [TN];
   logic signed [34:0] p_acc_ff   [TN];

   logic               d_valid_ff [TN];
   logic [30:0]        d_term_ff  [TN];
   logic [31:0]        d_t2_ff    [TN];
   logic signed [34:0] d_acc_ff   [TN];

   logic signed [34:0] f_sum_in;
   logic [30:0]        f_sine_in;
   logic               f_valid_ff;
   logic [30:0]        f_sine_ff;

   assign t_prod_in = PW'(in_uf) * PW'(urb_pkg::PI_HALF_Q30) + T_HALF;
   assign a_t_in = t_prod_in[FRAC_BITS +: 31];
   assign b_sq_in = 62'(a_t_ff) * 62'(a_t_ff) + SQ_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_t_ff <= a_t_in;
      b_t_ff <= a_t_ff;
      b_t2_ff <= b_sq_in[61:30];
      b_acc_ff <= $signed(35'(a_t_ff));
   end

   for (genvar n = 0; n < TN; n++) begin : g_term
      logic               src_valid;
      logic [30:0]        src_term;
      logic [31:0]        src_t2;
      logic signed [34:0] src_acc;
      logic [62:0]        prod_in;
      logic [31:0]        x_in;
      logic [64:0]        quot_in;
      logic [64:0]        shifted_in;

      if (n == 0) begin : g_first
         assign src_valid = b_valid_ff;
         assign src_term  = b_t_ff;
         assign src_t2    = b_t2_ff;
         assign src_acc   = b_acc_ff;
      end else begin : g_rest
         assign src_valid = d_valid_ff[n-1];
         assign src_term  = d_term_ff[n-1];
         assign src_t2    = d_t2_ff[n-1];
         // Odd-numbered terms of the series are subtracted.
         if (n % 2 == 1) begin : g_neg
            assign src_acc = d_acc_ff[n-1] - $signed(35'(d_term_ff[n-1]));
         end else begin : g_pos
            assign src_acc = d_acc_ff[n-1] + $signed(35'(d_term_ff[n-1]));
         end
      end

      assign prod_in = 63'(src_term) * 63'(src_t2) + PR_HALF;
      assign x_in = prod_in[61:30] + 32'(urb_pkg::term_half(n + 1));
      assign quot_in = 65'(p_x_ff[n]) * 65'(urb_pkg::term_mult(n + 1));
      assign shifted_in = quot_in >> urb_pkg::term_shift(n + 1);

      always_ff @(posedge clock) begin
         if (reset) begin
            p_valid_ff[n] <= 1'b0;
            d_valid_ff[n] <= 1'b0;
         end else begin
            p_valid_ff[n] <= src_valid;
            d_valid_ff[n] <= p_valid_ff[n];
         end
      end

      always_ff @(posedge clock) begin
         p_x_ff[n]    <= x_in;
         p_t2_ff[n]   <= src_t2;
         p_acc_ff[n]  <= src_acc;
         d_term_ff[n] <= shifted_in[30:0];
         d_t2_ff[n]   <= p_t2_ff[n];
         d_acc_ff[n]  <= p_acc_ff[n];
      end
   end

   // The last term has an even index and is added.
   assign f_sum_in = d_acc_ff[TN-1] + $signed(35'(d_term_ff[TN-1]));

   always_comb begin
      if (f_sum_in <= 35'sd0) begin
         f_sine_in = 31'd0;
      end else if (f_sum_in > ACC_ONE) begin
         f_sine_in = urb_pkg::Q_ONE;
      end else begin
         f_sine_in = f_sum_in[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= d_valid_ff[TN-1];
      end
   end

   always_ff @(posedge clock) begin
      f_sine_ff <= f_sine_in;
   end

   assign out_valid = f_valid_ff;
   assign out_sine = f_sine_ff;

endmodule

>>> src/urb_div.sv
module urb_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [51:0]              in_dividend,
   input  logic [21:0]              in_divisor,
   input  urb_pkg::urb_side_type    in_side,
   output logic                     out_valid,
   output logic [30:0]              out_quotient,
   output urb_pkg::urb_side_type    out_side
);

   localparam int QW = urb_pkg::QUO_W;
   localparam int DW = urb_pkg::DEN_W;
   localparam int VW = urb_pkg::DVD_W;

   logic                  st_valid_ff [QW];
   logic [DW-1:0]         st_rem_ff   [QW];
   logic [QW-1:0]         st_quo_ff   [QW];
   logic [VW-1:0]         st_dvd_ff   [QW];
   urb_pkg::urb_side_type st_side_ff  [QW];

   // One quotient bit per stage; the remainder always stays below the divisor.
   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic                  src_valid;
      logic [DW-1:0]         src_rem;
      logic [QW-1:0]         src_quo;
      logic [VW-1:0]         src_dvd;
      urb_pkg::urb_side_type src_side;
      logic [DW:0]           trial_in;
      logic [DW:0]           diff_in;
      logic                  ge_in;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = DW'(in_dividend[VW-1:QW]);
         assign src_quo   = '0;
         assign src_dvd   = in_dividend;
         assign src_side  = in_side;
      end else begin : g_rest
         assign src_valid = st_valid_ff[k-1];
         assign src_rem   = st_rem_ff[k-1];
         assign src_quo   = st_quo_ff[k-1];
         assign src_dvd   = st_dvd_ff[k-1];
         assign src_side  = st_side_ff[k-1];
      end

      assign trial_in = {src_rem, src_dvd[QW-1-k]};
      assign ge_in = trial_in >= {1'b0, in_divisor};
      assign diff_in = trial_in - {1'b0, in_divisor};

      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[k] <= 1'b0;
         end else begin
            st_valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         st_rem_ff[k]  <= ge_in ? diff_in[DW-1:0] : trial_in[DW-1:0];
         st_quo_ff[k]  <= {src_quo[QW-2:0], ge_in};
         st_dvd_ff[k]  <= src_dvd;
         st_side_ff[k] <= src_side;
      end
   end

   assign out_valid = st_valid_ff[QW-1];
   assign out_quotient = st_quo_ff[QW-1];
   assign out_side = st_side_ff[QW-1];

endmodule

>>> src/unfrozen_relperm_blend_unit.sv
// Relative permeability of partly frozen water, one request per clock with no
// gaps while busy is low. Every request accepted (start high while busy is low)
// gives exactly one result, shown on rsp_kr for a single cycle with rsp_valid
// high. The pipeline holds an entry register, 19 stages of fixed point sine
// series, one multiplier stage per possible power step, a numerator register
// and a 31 stage restoring divider for the blend, then an output register.
// There is no way to hold a result back, so the receiver must take it in the
// cycle it appears. busy is high only during reset. Cutoff and exponent writes
// on the csr_ port are meant for an empty pipeline.
module unfrozen_relperm_blend_unit #(
   parameter int FRAC_BITS = 16,
   parameter int EXPONENT_MAX = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [FRAC_BITS:0]  req_unfrozen_fraction,
   input  logic signed [31:0]  req_pressure,
   output logic                rsp_valid,
   output logic [FRAC_BITS:0]  rsp_kr,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [21:0]         csr_data
);

   localparam int SL = urb_pkg::SINE_LATENCY;
   localparam int EM = EXPONENT_MAX;
   localparam logic [FRAC_BITS:0] UF_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
   localparam logic [5:0] ALPHA_MAX = 6'(EXPONENT_MAX & ~1);
   localparam logic [61:0] PW_HALF = 62'(1) << 29;
   localparam logic [30:0] RND_HALF = 31'(1) << (29 - FRAC_BITS);

   // Configuration registers.
   logic [4:0]         pe_ff, pe_in;
   logic signed [21:0] upper_ff, upper_in;
   logic signed [21:0] lower_ff, lower_in;
   logic [21:0]        den_ff;
   logic signed [22:0] den_in;

   assign csr_ready = ~reset;
   assign busy = reset;

   always_comb begin
      pe_in = pe_ff;
      upper_in = upper_ff;
      lower_in = lower_ff;
      if (csr_valid && csr_ready) begin
         case (urb_pkg::urb_csr_type'(csr_index))
            urb_pkg::CSR_POWER_EXPONENT: pe_in = csr_data[4:0];
            urb_pkg::CSR_UPPER_CUTOFF:   upper_in = $signed(csr_data);
            urb_pkg::CSR_LOWER_CUTOFF:   lower_in = $signed(csr_data);
            default: ;
         endcase
      end
      den_in = 23'(upper_in) - 23'(lower_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pe_ff <= urb_pkg::PE_RESET;
         upper_ff <= urb_pkg::UPPER_RESET;
         lower_ff <= urb_pkg::LOWER_RESET;
         den_ff <= 22'(urb_pkg::UPPER_RESET - urb_pkg::LOWER_RESET);
      end else begin
         pe_ff <= pe_in;
         upper_ff <= upper_in;
         lower_ff <= lower_in;
         den_ff <= den_in[21:0];
      end
   end

   // Entry stage: saturate the fraction and classify the pressure.
   logic signed [33:0]    h_in, hi_in, lo_in, num_wide_in;
   logic [FRAC_BITS:0]    uf_in;
   urb_pkg::urb_class_type cls_in;
   logic                  s0_valid_ff;
   logic [FRAC_BITS:0]    s0_uf_ff;
   urb_pkg::urb_class_type s0_cls_ff;
   logic [21:0]           s0_num_ff;

   assign h_in = 34'(req_pressure);
   assign hi_in = urb_pkg::ATM_UNITS + 34'(upper_ff);
   assign lo_in = urb_pkg::ATM_UNITS + 34'(lower_ff);
   assign num_wide_in = h_in - lo_in;
   assign uf_in = (req_unfrozen_fraction > UF_ONE) ? UF_ONE : req_unfrozen_fraction;

   always_comb begin
      if (h_in >= hi_in) begin
         cls_in = urb_pkg::CLS_FULL;
      end else if (h_in <= lo_in) begin
         cls_in = urb_pkg::CLS_ONE;
      end else begin
         cls_in = urb_pkg::CLS_BLEND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      s0_uf_ff <= uf_in;
      s0_cls_ff <= cls_in;
      s0_num_ff <= num_wide_in[21:0];
   end

   // Sine pipeline, with the class and offset delayed alongside it.
   logic        sn_valid;
   logic [30:0] sn_sine;
   urb_pkg::urb_class_type dl_cls_ff [SL];
   logic [21:0]            dl_num_ff [SL];

   urb_sine #(.FRAC_BITS(FRAC_BITS)) u_sine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_uf     (s0_uf_ff),
      .out_valid (sn_valid),
      .out_sine  (sn_sine)
   );

   always_ff @(posedge clock) begin
      dl_cls_ff[0] <= s0_cls_ff;
      dl_num_ff[0] <= s0_num_ff;
      for (int k = 1; k < SL; k++) begin
         dl_cls_ff[k] <= dl_cls_ff[k-1];
         dl_num_ff[k] <= dl_num_ff[k-1];
      end
   end

   // Power stages: stage i multiplies once more while i is below alpha.
   logic [5:0] alpha_raw;
   logic [5:0] alpha_eff;
   logic                   pw_valid_ff [EM];
   logic [30:0]            pw_p_ff     [EM];
   logic [30:0]            pw_s_ff     [EM];
   urb_pkg::urb_class_type pw_cls_ff   [EM];
   logic [21:0]            pw_num_ff   [EM];

   assign alpha_raw = {1'b0, pe_ff[4:1], 1'b0};
   assign alpha_eff = (alpha_raw > ALPHA_MAX) ? ALPHA_MAX : alpha_raw;

   for (genvar i = 0; i < EM; i++) begin : g_power
      logic                   src_valid;
      logic [30:0]            src_p;
      logic [30:0]            src_s;
      urb_pkg::urb_class_type src_cls;
      logic [21:0]            src_num;
      logic [61:0]            prod_in;

      if (i == 0) begin : g_first
         assign src_valid = sn_valid;
         assign src_p     = urb_pkg::Q_ONE;
         assign src_s     = sn_sine;
         assign src_cls   = dl_cls_ff[SL-1];
         assign src_num   = dl_num_ff[SL-1];
      end else begin : g_rest
         assign src_valid = pw_valid_ff[i-1];
         assign src_p     = pw_p_ff[i-1];
         assign src_s     = pw_s_ff[i-1];
         assign src_cls   = pw_cls_ff[i-1];
         assign src_num   = pw_num_ff[i-1];
      end

      assign prod_in = 62'(src_p) * 62'(src_s) + PW_HALF;

      always_ff @(posedge clock) begin
         if (reset) begin
            pw_valid_ff[i] <= 1'b0;
         end else begin
            pw_valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         pw_p_ff[i] <= (6'(i) < alpha_eff) ? prod_in[60:30] : src_p;
         pw_s_ff[i] <= src_s;
         pw_cls_ff[i] <= src_cls;
         pw_num_ff[i] <= src_num;
      end
   end

   // Blend numerator: offset times (1 - P), plus half the span for rounding.
   logic [30:0] omp_in;
   logic [52:0] dvd_in;
   logic        m_valid_ff;
   logic [51:0] m_dvd_ff;
   urb_pkg::urb_side_type m_side_ff;

   assign omp_in = urb_pkg::Q_ONE - pw_p_ff[EM-1];
   assign dvd_in = 53'(pw_num_ff[EM-1]) * 53'(omp_in) + 53'(den_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= pw_valid_ff[EM-1];
      end
   end

   always_ff @(posedge clock) begin
      m_dvd_ff <= dvd_in[51:0];
      m_side_ff.cls <= pw_cls_ff[EM-1];
      m_side_ff.p <= pw_p_ff[EM-1];
   end

   logic        dv_valid;
   logic [30:0] dv_quo;
   urb_pkg::urb_side_type dv_side;

   urb_div u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (m_valid_ff),
      .in_dividend  (m_dvd_ff),
      .in_divisor   (den_ff),
      .in_side      (m_side_ff),
      .out_valid    (dv_valid),
      .out_quotient (dv_quo),
      .out_side     (dv_side)
   );

   // Final selection and rounding to the output format.
   logic [30:0]        kr_in;
   logic [30:0]        kr_rnd_in;
   logic [FRAC_BITS:0] rp_in;
   logic               rsp_valid_ff;
   logic [FRAC_BITS:0] rsp_rp_ff;

   always_comb begin
      case (dv_side.cls)
         urb_pkg::CLS_FULL: kr_in = dv_side.p;
         urb_pkg::CLS_ONE:  kr_in = urb_pkg::Q_ONE;
         default:           kr_in = (dv_quo > urb_pkg::Q_ONE) ? 31'd0
                                                              : urb_pkg::Q_ONE - dv_quo;
      endcase
      kr_rnd_in = kr_in + RND_HALF;
      rp_in = kr_rnd_in[30 -: (FRAC_BITS + 1)];
      if (rp_in > UF_ONE) begin
         rp_in = UF_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rp_ff <= rp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kr = rsp_rp_ff;

endmodule

>>> src/urb_checker.sv
`include "unfrozen_relperm_blend_unit_macros.svh"

module urb_checker #(
   parameter int FRAC_BITS = 16,
   parameter int EXPONENT_MAX = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [FRAC_BITS:0] rsp_kr
);

   localparam int LATENCY = 53 + EXPONENT_MAX;
   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   // Every accepted request comes out after LATENCY, and nothing else does.
   `URB_ASSERT_DELAY(a_result_follows, start && !busy, LATENCY, rsp_valid)
   `URB_ASSERT_DELAY(a_no_extra_result, !(start && !busy), LATENCY, !rsp_valid)
   `URB_ASSERT_NOW(a_result_range, rsp_valid, rsp_kr <= ONE)

endmodule

bind unfrozen_relperm_blend_unit urb_checker #(
   .FRAC_BITS    (FRAC_BITS),
   .EXPONENT_MAX (EXPONENT_MAX)
) u_urb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_kr    (rsp_kr)
);
